>>> rtl/core/rvx_pkg.sv
// Shared types, codes and constants for the register machine executor.
`default_nettype none
package rvx_pkg;

  localparam int REG_COUNT_DEF = 8;
  localparam int MEM_BYTES_DEF = 1024;
  localparam int WORD_BITS_DEF = 64;

  localparam int CMD_W   = 8;
  localparam int IDX_W   = 8;
  localparam int IMM_W   = 64;
  localparam int OPC_W   = 10;
  localparam int PIDX_W  = 3;
  localparam int PVAL_W  = 64;
  localparam int ST_W    = 3;
  localparam int LEN_W   = 4;

  localparam logic [LEN_W-1:0] LEN_HALT  = 4'd1;
  localparam logic [LEN_W-1:0] LEN_LOADI = 4'd10;
  localparam logic [LEN_W-1:0] LEN_ARITH = 4'd4;
  localparam logic [LEN_W-1:0] LEN_PRINT = 4'd2;
  localparam logic [LEN_W-1:0] LEN_JZ    = 4'd10;

  typedef enum logic [CMD_W-1:0] {
    OP_HALT  = 8'd0,
    OP_LOADI = 8'd1,
    OP_ADD   = 8'd2,
    OP_SUB   = 8'd3,
    OP_MUL   = 8'd4,
    OP_DIV   = 8'd5,
    OP_PRINT = 8'd6,
    OP_JUMP  = 8'd7,
    OP_JZ    = 8'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_DIV0    = 3'd2,
    ST_BADOP   = 3'd3,
    ST_BADREG  = 3'd4,
    ST_BADADDR = 3'd5
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_ITER,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic instr_load;
    logic exec_latch;
    logic iter_start;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_iter;
    logic iter_busy;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/rvx_ctrl.sv
// Sequencing state machine for the register machine executor.
`default_nettype none
module rvx_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rvx_pkg::dp_sts_t  sts,
  output rvx_pkg::ctl_cmd_t      cmd
);
  import rvx_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = sts.need_iter ? S_ITER : S_FINISH;
      end
      S_ITER: begin
        if (!sts.iter_busy) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != S_IDLE);
    cmd.instr_load = (state_r == S_IDLE) && in_valid;
    cmd.exec_latch = (state_r == S_EXEC);
    cmd.iter_start = (state_r == S_EXEC) && sts.need_iter;
    cmd.commit     = (state_r == S_FINISH) && sts.out_free;
  end

endmodule
`default_nettype wire

>>> rtl/core/rvx_iter.sv
// Shared one-bit-per-cycle shift-add multiplier and restoring divider.
`default_nettype none
module rvx_iter #(
  parameter int WORD_BITS = rvx_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 op_div,
  input  wire logic [WORD_BITS-1:0] opa,
  input  wire logic [WORD_BITS-1:0] opb,
  output logic                      busy,
  output logic [WORD_BITS-1:0]      result
);
  import rvx_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 div_r;
  logic [WORD_BITS-1:0] x_r;
  logic [WORD_BITS-1:0] y_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] x_nxt;
  logic [WORD_BITS-1:0] y_nxt;
  logic [WORD_BITS-1:0] acc_nxt;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;

  always_comb begin
    rem_sh  = {x_r, y_r[WORD_BITS-1]};
    diff    = rem_sh - {1'b0, b_r};
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    if (div_r) begin
      if (!diff[WORD_BITS]) begin
        x_nxt = diff[WORD_BITS-1:0];
        y_nxt = {y_r[WORD_BITS-2:0], 1'b1};
      end else begin
        x_nxt = rem_sh[WORD_BITS-1:0];
        y_nxt = {y_r[WORD_BITS-2:0], 1'b0};
      end
    end else begin
      if (y_r[0]) acc_nxt = acc_r + x_r;
      x_nxt = {x_r[WORD_BITS-2:0], 1'b0};
      y_nxt = {1'b0, y_r[WORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= op_div;
      b_r   <= opb;
      acc_r <= '0;
      if (op_div) begin
        x_r <= '0;
        y_r <= opa;
      end else begin
        x_r <= opa;
        y_r <= opb;
      end
    end else if (busy_r) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign busy   = busy_r;
  assign result = div_r ? y_r : acc_r;

endmodule
`default_nettype wire

>>> rtl/core/rvx_dpath.sv
// Datapath: instruction latch, register file, pc, stop code, result register.
`default_nettype none
module rvx_dpath #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF,
  parameter int MEM_BYTES = rvx_pkg::MEM_BYTES_DEF,
  parameter int WORD_BITS = rvx_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rvx_pkg::ctl_cmd_t          cmd,
  output rvx_pkg::dp_sts_t                sts,
  input  wire logic [rvx_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_first,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_second,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_third,
  input  wire logic [rvx_pkg::IMM_W-1:0]  in_immediate,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rvx_pkg::OPC_W-1:0]       out_next_pc,
  output logic                            out_print_valid,
  output logic [rvx_pkg::PIDX_W-1:0]      out_print_index,
  output logic [rvx_pkg::PVAL_W-1:0]      out_print_value,
  output logic [rvx_pkg::ST_W-1:0]        out_status
);
  import rvx_pkg::*;

  localparam int RIDX_W = $clog2(REG_COUNT);
  localparam int PC_W   = $clog2(MEM_BYTES);
  localparam logic [IDX_W-1:0] REG_LIM = IDX_W'(REG_COUNT);
  localparam logic [PC_W:0]    MEM_LIM = (PC_W + 1)'(MEM_BYTES);
  localparam logic [IMM_W-1:0] IMM_LIM = IMM_W'(MEM_BYTES);

  function automatic logic [PC_W-1:0] adv(input logic [PC_W-1:0] pc,
                                          input logic [LEN_W-1:0] len);
    logic [PC_W:0] s;
    s = {1'b0, pc} + (PC_W + 1)'(len);
    if (s >= MEM_LIM) s = s - MEM_LIM;
    return s[PC_W-1:0];
  endfunction

  logic [CMD_W-1:0]     ins_cmd_r;
  logic [IDX_W-1:0]     ins_ra_r;
  logic [IDX_W-1:0]     ins_rb_r;
  logic [IDX_W-1:0]     ins_rc_r;
  logic [IMM_W-1:0]     ins_imm_r;

  logic [WORD_BITS-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [WORD_BITS-1:0] rd_a_r;
  logic [WORD_BITS-1:0] rd_b_r;
  logic [RIDX_W-1:0]    addr_a;
  logic [RIDX_W-1:0]    addr_b;
  logic [RIDX_W-1:0]    addr_w;
  logic                 is_arith;

  logic [PC_W-1:0]      pc_r;
  st_t                  stop_r;

  logic [PC_W-1:0]      npc_nxt;
  st_t                  st_nxt;
  logic                 pv_nxt;
  logic [PIDX_W-1:0]    pidx_nxt;
  logic [WORD_BITS-1:0] pval_nxt;
  logic                 we_nxt;
  logic [WORD_BITS-1:0] wval_nxt;
  logic                 iter_nxt;
  logic                 ra_ok;
  logic                 rb_ok;
  logic                 rc_ok;
  logic                 imm_ok;

  logic [PC_W-1:0]      res_npc_r;
  st_t                  res_st_r;
  logic                 res_pv_r;
  logic [PIDX_W-1:0]    res_pidx_r;
  logic [WORD_BITS-1:0] res_pval_r;
  logic                 res_we_r;
  logic                 res_iter_r;
  logic [WORD_BITS-1:0] res_wval_r;
  logic [WORD_BITS-1:0] wdata;

  logic                 out_valid_r;
  logic                 iter_busy;
  logic [WORD_BITS-1:0] iter_result;

  always_ff @(posedge clk) begin
    if (cmd.instr_load) begin
      ins_cmd_r <= in_cmd;
      ins_ra_r  <= in_reg_first;
      ins_rb_r  <= in_reg_second;
      ins_rc_r  <= in_reg_third;
      ins_imm_r <= in_immediate;
    end
  end

  assign is_arith = (ins_cmd_r == OP_ADD) || (ins_cmd_r == OP_SUB) ||
                    (ins_cmd_r == OP_MUL) || (ins_cmd_r == OP_DIV);
  assign addr_a   = is_arith ? ins_rb_r[RIDX_W-1:0] : ins_ra_r[RIDX_W-1:0];
  assign addr_b   = ins_rc_r[RIDX_W-1:0];
  assign addr_w   = ins_ra_r[RIDX_W-1:0];
  assign wdata    = res_iter_r ? iter_result : res_wval_r;

  always_ff @(posedge clk) begin
    if (cmd.commit && res_we_r) mem[addr_w] <= wdata;
    rd_a_r <= (32'(addr_a) < REG_COUNT && vld_r[addr_a]) ? mem[addr_a] : '0;
    rd_b_r <= (32'(addr_b) < REG_COUNT && vld_r[addr_b]) ? mem[addr_b] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      pc_r   <= '0;
      stop_r <= ST_OK;
    end else if (cmd.commit) begin
      if (res_we_r) vld_r[addr_w] <= 1'b1;
      pc_r   <= res_npc_r;
      stop_r <= res_st_r;
    end
  end

  always_comb begin
    ra_ok    = ins_ra_r < REG_LIM;
    rb_ok    = ins_rb_r < REG_LIM;
    rc_ok    = ins_rc_r < REG_LIM;
    imm_ok   = ins_imm_r < IMM_LIM;
    npc_nxt  = pc_r;
    st_nxt   = ST_OK;
    pv_nxt   = 1'b0;
    pidx_nxt = '0;
    pval_nxt = '0;
    we_nxt   = 1'b0;
    wval_nxt = '0;
    iter_nxt = 1'b0;
    if (stop_r != ST_OK) begin
      st_nxt = stop_r;
    end else begin
      unique case (ins_cmd_r)
        OP_HALT: begin
          npc_nxt = adv(pc_r, LEN_HALT);
          st_nxt  = ST_HALT;
        end
        OP_LOADI: begin
          if (!ra_ok) begin
            st_nxt = ST_BADREG;
          end else begin
            we_nxt   = 1'b1;
            wval_nxt = ins_imm_r[WORD_BITS-1:0];
            npc_nxt  = adv(pc_r, LEN_LOADI);
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (!(ra_ok && rb_ok && rc_ok)) begin
            st_nxt = ST_BADREG;
          end else if (ins_cmd_r == OP_DIV && rd_b_r == '0) begin
            st_nxt = ST_DIV0;
          end else begin
            we_nxt   = 1'b1;
            wval_nxt = (ins_cmd_r == OP_ADD) ? rd_a_r + rd_b_r : rd_a_r - rd_b_r;
            iter_nxt = (ins_cmd_r == OP_MUL) || (ins_cmd_r == OP_DIV);
            npc_nxt  = adv(pc_r, LEN_ARITH);
          end
        end
        OP_PRINT: begin
          if (!ra_ok) begin
            st_nxt = ST_BADREG;
          end else begin
            pv_nxt   = 1'b1;
            pidx_nxt = ins_ra_r[PIDX_W-1:0];
            pval_nxt = rd_a_r;
            npc_nxt  = adv(pc_r, LEN_PRINT);
          end
        end
        OP_JUMP: begin
          if (!imm_ok) st_nxt = ST_BADADDR;
          else npc_nxt = ins_imm_r[PC_W-1:0];
        end
        OP_JZ: begin
          if (!ra_ok) begin
            st_nxt = ST_BADREG;
          end else if (rd_a_r == '0) begin
            if (!imm_ok) st_nxt = ST_BADADDR;
            else npc_nxt = ins_imm_r[PC_W-1:0];
          end else begin
            npc_nxt = adv(pc_r, LEN_JZ);
          end
        end
        default: st_nxt = ST_BADOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_latch) begin
      res_npc_r  <= npc_nxt;
      res_st_r   <= st_nxt;
      res_pv_r   <= pv_nxt;
      res_pidx_r <= pidx_nxt;
      res_pval_r <= pval_nxt;
      res_we_r   <= we_nxt;
      res_iter_r <= iter_nxt;
      res_wval_r <= wval_nxt;
    end
  end

  rvx_iter #(
    .WORD_BITS (WORD_BITS)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.iter_start),
    .op_div (ins_cmd_r == OP_DIV),
    .opa    (rd_a_r),
    .opb    (rd_b_r),
    .busy   (iter_busy),
    .result (iter_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_next_pc     <= OPC_W'(res_npc_r);
      out_print_valid <= res_pv_r;
      out_print_index <= res_pidx_r;
      out_print_value <= PVAL_W'(res_pval_r);
      out_status      <= res_st_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.need_iter = iter_nxt;
  assign sts.iter_busy = iter_busy;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> rtl/core/register_vm_instruction_executor_core.sv
// Each accepted beat passes through the decode, execute and finish states before
// out_valid; mul and div also wait in the iterate state for the one-bit-per-cycle
// shift-add and restoring divide unit; one instruction is in work at a time.
// A new beat is taken only once the previous one has committed, and a finished
// beat waits in the finish state for the output register to free up.
// Reset (synchronous, rst_n low) clears registers to zero, pc to zero and
// the stop code to running; the register file is cleared through valid bits.
`default_nettype none
module register_vm_instruction_executor_core #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF,
  parameter int MEM_BYTES = rvx_pkg::MEM_BYTES_DEF,
  parameter int WORD_BITS = rvx_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rvx_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_first,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_second,
  input  wire logic [rvx_pkg::IDX_W-1:0]  in_reg_third,
  input  wire logic [rvx_pkg::IMM_W-1:0]  in_immediate,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rvx_pkg::OPC_W-1:0]       out_next_pc,
  output logic                            out_print_valid,
  output logic [rvx_pkg::PIDX_W-1:0]      out_print_index,
  output logic [rvx_pkg::PVAL_W-1:0]      out_print_value,
  output logic [rvx_pkg::ST_W-1:0]        out_status
);
  import rvx_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  rvx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  rvx_dpath #(
    .REG_COUNT (REG_COUNT),
    .MEM_BYTES (MEM_BYTES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctl_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_cmd),
    .in_reg_first    (in_reg_first),
    .in_reg_second   (in_reg_second),
    .in_reg_third    (in_reg_third),
    .in_immediate    (in_immediate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_print_valid (out_print_valid),
    .out_print_index (out_print_index),
    .out_print_value (out_print_value),
    .out_status      (out_status)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> (!out_valid || !out_stall))
    else $error("result committed over an unaccepted beat");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while one is in work");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.iter_start |=> dp_sts.iter_busy)
    else $error("iterative unit did not start");

endmodule
`default_nettype wire

>>> verif/register_vm_instruction_executor_core_test.sv
// Testbench for the register machine instruction executor: directed and random programs.
module register_vm_instruction_executor_core_test;
  import rvx_pkg::*;

  localparam int REG_COUNT = REG_COUNT_DEF;
  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam int WORD_BITS = WORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [IDX_W-1:0] NO_REG = 8'hFF;
  localparam op_t ARITH_OPS [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] reg_first;
    logic [IDX_W-1:0] reg_second;
    logic [IDX_W-1:0] reg_third;
    logic [IMM_W-1:0] immediate;
  } vm_instr_t;

  typedef struct packed {
    logic [OPC_W-1:0]  next_pc;
    logic              print_valid;
    logic [PIDX_W-1:0] print_index;
    logic [PVAL_W-1:0] print_value;
    st_t               status;
  } vm_result_t;

  typedef enum int {
    CAUSE_HALT,
    CAUSE_DIV0,
    CAUSE_BADOP,
    CAUSE_BADREG_ONE,
    CAUSE_BADREG_ARITH,
    CAUSE_BADADDR_JUMP,
    CAUSE_BADADDR_JZ
  } stop_cause_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0] in_reg_first;
  logic [IDX_W-1:0] in_reg_second;
  logic [IDX_W-1:0] in_reg_third;
  logic [IMM_W-1:0] in_immediate;
  logic out_valid;
  logic out_stall;
  logic [OPC_W-1:0] out_next_pc;
  logic out_print_valid;
  logic [PIDX_W-1:0] out_print_index;
  logic [PVAL_W-1:0] out_print_value;
  logic [ST_W-1:0] out_status;

  logic [WORD_BITS-1:0] vm_regs [REG_COUNT];
  logic [OPC_W-1:0] vm_pc;
  st_t vm_stop;
  vm_result_t predicted_results [$];
  vm_result_t got_result;

  int error_count;
  int cycle_count;
  int burst_left;
  bit gaps_on;
  int stall_mode;
  int stall_left;
  int stall_tick;

  register_vm_instruction_executor_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_reg_first    (in_reg_first),
    .in_reg_second   (in_reg_second),
    .in_reg_third    (in_reg_third),
    .in_immediate    (in_immediate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_print_valid (out_print_valid),
    .out_print_index (out_print_index),
    .out_print_value (out_print_value),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [OPC_W-1:0] pc_after(input int len);
    return OPC_W'((int'(vm_pc) + len) % MEM_BYTES);
  endfunction

  task automatic execute_instruction(input vm_instr_t ins);
    vm_result_t res;
    logic [WORD_BITS-1:0] lhs;
    logic [WORD_BITS-1:0] rhs;
    logic [WORD_BITS-1:0] val;
    logic [OPC_W-1:0] npc;
    st_t st;
    res = '0;
    npc = vm_pc;
    st = ST_OK;
    if (vm_stop != ST_OK) begin
      st = vm_stop;
    end else begin
      case (ins.cmd)
        OP_HALT: begin
          npc = pc_after(LEN_HALT);
          st = ST_HALT;
        end
        OP_LOADI: begin
          if (ins.reg_first >= REG_COUNT) begin
            st = ST_BADREG;
          end else begin
            vm_regs[ins.reg_first] = ins.immediate[WORD_BITS-1:0];
            npc = pc_after(LEN_LOADI);
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (ins.reg_first >= REG_COUNT || ins.reg_second >= REG_COUNT ||
              ins.reg_third >= REG_COUNT) begin
            st = ST_BADREG;
          end else begin
            lhs = vm_regs[ins.reg_second];
            rhs = vm_regs[ins.reg_third];
            if (ins.cmd == OP_DIV && rhs == '0) begin
              st = ST_DIV0;
            end else begin
              case (ins.cmd)
                OP_ADD: val = lhs + rhs;
                OP_SUB: val = lhs - rhs;
                OP_MUL: val = lhs * rhs;
                default: val = lhs / rhs;
              endcase
              vm_regs[ins.reg_first] = val;
              npc = pc_after(LEN_ARITH);
            end
          end
        end
        OP_PRINT: begin
          if (ins.reg_first >= REG_COUNT) begin
            st = ST_BADREG;
          end else begin
            res.print_valid = 1'b1;
            res.print_index = ins.reg_first[PIDX_W-1:0];
            res.print_value = vm_regs[ins.reg_first];
            npc = pc_after(LEN_PRINT);
          end
        end
        OP_JUMP: begin
          if (ins.immediate >= MEM_BYTES) st = ST_BADADDR;
          else npc = ins.immediate[OPC_W-1:0];
        end
        OP_JZ: begin
          if (ins.reg_first >= REG_COUNT) begin
            st = ST_BADREG;
          end else if (vm_regs[ins.reg_first] == '0) begin
            if (ins.immediate >= MEM_BYTES) st = ST_BADADDR;
            else npc = ins.immediate[OPC_W-1:0];
          end else begin
            npc = pc_after(LEN_JZ);
          end
        end
        default: st = ST_BADOP;
      endcase
      vm_pc = npc;
      vm_stop = st;
    end
    res.next_pc = npc;
    res.status = st;
    predicted_results.insert(predicted_results.size(), res);
  endtask

  function automatic vm_instr_t instr(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] ra, rb, rc,
                                      input logic [IMM_W-1:0] imm);
    vm_instr_t ins;
    ins.cmd = cmd;
    ins.reg_first = ra;
    ins.reg_second = rb;
    ins.reg_third = rc;
    ins.immediate = imm;
    return ins;
  endfunction

  function automatic logic [IDX_W-1:0] rand_byte();
    return IDX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_W-1:0] rand_reg();
    return IDX_W'($urandom_range(0, REG_COUNT - 1));
  endfunction

  function automatic logic [IMM_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return IMM_W'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [IMM_W-1:0] rand_target();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return IMM_W'(MEM_BYTES - 1);
      2: return IMM_W'($urandom_range(MEM_BYTES - 12, MEM_BYTES - 1));
      default: return IMM_W'($urandom_range(0, MEM_BYTES - 1));
    endcase
  endfunction

  // Build an instruction that keeps the machine running, given the predicted state.
  function automatic vm_instr_t gen_program_beat();
    vm_instr_t ins;
    int pick;
    int start;
    int k;
    bit found;
    ins = instr(OP_LOADI, rand_byte(), rand_byte(), rand_byte(), {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      ins.reg_first = rand_reg();
      ins.immediate = rand_word();
    end else if (pick < 62) begin
      ins.cmd = ARITH_OPS[$urandom_range(0, 3)];
      ins.reg_first = rand_reg();
      ins.reg_second = rand_reg();
      ins.reg_third = rand_reg();
      if (ins.cmd == OP_DIV && vm_regs[ins.reg_third] == '0) begin
        found = 1'b0;
        start = $urandom_range(0, REG_COUNT - 1);
        for (k = 0; k < REG_COUNT; k++) begin
          if (!found && vm_regs[(start + k) % REG_COUNT] != '0) begin
            ins.reg_third = IDX_W'((start + k) % REG_COUNT);
            found = 1'b1;
          end
        end
        if (!found) begin
          ins.cmd = OP_LOADI;
          ins.immediate = rand_word();
        end
      end
    end else if (pick < 77) begin
      ins.cmd = OP_PRINT;
      ins.reg_first = rand_reg();
    end else if (pick < 85) begin
      ins.cmd = OP_JUMP;
      ins.immediate = rand_target();
    end else begin
      ins.cmd = OP_JZ;
      ins.reg_first = rand_reg();
      if (vm_regs[ins.reg_first] == '0) ins.immediate = rand_target();
    end
    return ins;
  endfunction

  task automatic send_beat(input vm_instr_t ins);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= ins.cmd;
    in_reg_first <= ins.reg_first;
    in_reg_second <= ins.reg_second;
    in_reg_third <= ins.reg_third;
    in_immediate <= ins.immediate;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    execute_instruction(ins);
  endtask

  task automatic test_reset_state();
    send_beat(instr(OP_PRINT, 8'd0, NO_REG, NO_REG, '1));
    send_beat(instr(OP_PRINT, 8'd7, NO_REG, NO_REG, '1));
  endtask

  task automatic test_arith_extremes();
    send_beat(instr(OP_LOADI, 8'd1, NO_REG, NO_REG, '1));
    send_beat(instr(OP_LOADI, 8'd2, NO_REG, NO_REG, 64'd1));
    send_beat(instr(OP_ADD, 8'd3, 8'd1, 8'd2, '1));
    send_beat(instr(OP_SUB, 8'd4, 8'd3, 8'd2, '1));
    send_beat(instr(OP_MUL, 8'd5, 8'd1, 8'd1, '1));
    send_beat(instr(OP_LOADI, 8'd6, NO_REG, NO_REG, 64'h8000_0000_0000_0000));
    send_beat(instr(OP_MUL, 8'd5, 8'd6, 8'd6, '1));
    send_beat(instr(OP_DIV, 8'd7, 8'd1, 8'd2, '1));
    send_beat(instr(OP_DIV, 8'd7, 8'd6, 8'd1, '1));
    send_beat(instr(OP_DIV, 8'd0, 8'd1, 8'd1, '1));
    send_beat(instr(OP_PRINT, 8'd7, NO_REG, NO_REG, '1));
    send_beat(instr(OP_PRINT, 8'd4, NO_REG, NO_REG, '1));
  endtask

  task automatic test_control_flow();
    send_beat(instr(OP_JUMP, NO_REG, NO_REG, NO_REG, IMM_W'(MEM_BYTES - 1)));
    send_beat(instr(OP_LOADI, 8'd3, NO_REG, NO_REG, '0));
    send_beat(instr(OP_JZ, 8'd3, NO_REG, NO_REG, '0));
    send_beat(instr(OP_JZ, 8'd2, NO_REG, NO_REG, '1));
    send_beat(instr(OP_JUMP, NO_REG, NO_REG, NO_REG, IMM_W'(MEM_BYTES - 4)));
    send_beat(instr(OP_ADD, 8'd0, 8'd0, 8'd0, '1));
    send_beat(instr(OP_JZ, 8'd3, NO_REG, NO_REG, IMM_W'(MEM_BYTES - 1)));
    send_beat(instr(OP_PRINT, 8'd1, NO_REG, NO_REG, '1));
    send_beat(instr(OP_JUMP, NO_REG, NO_REG, NO_REG, '0));
  endtask

  task automatic test_random_program();
    int i;
    for (i = 0; i < 470; i++) begin
      gaps_on = !(i >= 200 && i < 260);
      send_beat(gen_program_beat());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_stop_and_hold();
    stop_cause_t cause;
    vm_instr_t ins;
    logic [IDX_W-1:0] zero_reg;
    int i;
    cause = stop_cause_t'($urandom_range(CAUSE_HALT, CAUSE_BADADDR_JZ));
    zero_reg = rand_reg();
    ins = instr(OP_HALT, rand_byte(), rand_byte(), rand_byte(), {$urandom, $urandom});
    case (cause)
      CAUSE_DIV0: begin
        send_beat(instr(OP_LOADI, zero_reg, rand_byte(), rand_byte(), '0));
        ins = instr(OP_DIV, rand_reg(), rand_reg(), zero_reg, {$urandom, $urandom});
      end
      CAUSE_BADOP: begin
        ins.cmd = CMD_W'($urandom_range(OP_JZ + 1, 255));
      end
      CAUSE_BADREG_ONE: begin
        case ($urandom_range(0, 2))
          0: ins.cmd = OP_LOADI;
          1: ins.cmd = OP_PRINT;
          default: ins.cmd = OP_JZ;
        endcase
        ins.reg_first = IDX_W'($urandom_range(REG_COUNT, 255));
      end
      CAUSE_BADREG_ARITH: begin
        ins = instr(ARITH_OPS[$urandom_range(0, 3)], rand_reg(), rand_reg(), rand_reg(),
                    {$urandom, $urandom});
        case ($urandom_range(0, 2))
          0: ins.reg_first = IDX_W'($urandom_range(REG_COUNT, 255));
          1: ins.reg_second = IDX_W'($urandom_range(REG_COUNT, 255));
          default: ins.reg_third = IDX_W'($urandom_range(REG_COUNT, 255));
        endcase
      end
      CAUSE_BADADDR_JUMP: begin
        ins.cmd = OP_JUMP;
        ins.immediate = $urandom_range(0, 1) ? IMM_W'(MEM_BYTES) : {$urandom | 32'h1, $urandom};
      end
      CAUSE_BADADDR_JZ: begin
        send_beat(instr(OP_LOADI, zero_reg, rand_byte(), rand_byte(), '0));
        ins = instr(OP_JZ, zero_reg, rand_byte(), rand_byte(), '1);
        if ($urandom_range(0, 1)) ins.immediate = IMM_W'(MEM_BYTES);
      end
      default: ;
    endcase
    send_beat(ins);
    // hold: everything after the stop reports the frozen state
    for (i = 0; i < 20; i++) begin
      send_beat(instr(rand_byte(), rand_byte(), rand_byte(), rand_byte(), {$urandom, $urandom}));
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] expv,
                                      input logic [63:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result beat: next_pc %0d status %0d", out_next_pc, out_status);
        error_count++;
      end else begin
        got_result = predicted_results.pop_front();
        check_field("next_pc", 64'(got_result.next_pc), 64'(out_next_pc));
        check_field("print_valid", 64'(got_result.print_valid), 64'(out_print_valid));
        check_field("print_index", 64'(got_result.print_index), 64'(out_print_index));
        check_field("print_value", got_result.print_value, out_print_value);
        check_field("status", 64'(got_result.status), 64'(out_status));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 7 < 3);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("register_vm_instruction_executor_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < REG_COUNT; r++) vm_regs[r] = '0;
    vm_pc = '0;
    vm_stop = ST_OK;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    stall_mode = 0;
    stall_left = 0;
    stall_tick = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_reg_first = '0;
    in_reg_second = '0;
    in_reg_third = '0;
    in_immediate = '0;
    out_stall = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_arith_extremes();
    test_control_flow();
    test_random_program();
    test_stop_and_hold();

    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (WORD_BITS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("register_vm_instruction_executor_core_test OK");
    end else begin
      $display("register_vm_instruction_executor_core_test NOT OK");
    end
    $finish;
  end

endmodule
